[src/bti_pkg.sv]
// shared types, constants and defaults for the bilinear table interpolator
package bti_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int WGT_W  = 16;

    localparam int POINTS_X_DEF = 16;
    localparam int POINTS_Y_DEF = 16;

    localparam logic [DATA_W-1:0] X_ORIGIN_RST = 32'h0000_0000;
    localparam logic [DATA_W-1:0] Y_ORIGIN_RST = 32'h0000_0000;
    localparam logic [DATA_W-1:0] X_SCALE_RST  = 32'd983040;
    localparam logic [DATA_W-1:0] Y_SCALE_RST  = 32'd983040;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_ORIGIN = 2'd0,
        CFG_Y_ORIGIN = 2'd1,
        CFG_X_SCALE  = 2'd2,
        CFG_Y_SCALE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [0:0] {
        ACT_WRITE = 1'b0,
        ACT_EVAL  = 1'b1
    } t_action;

endpackage

[src/bti_position.sv]
// per-axis grid position: offset, scale multiply, clamp, split into index and weight
module bti_position import bti_pkg::*; #(
    parameter int POINTS = POINTS_X_DEF,
    localparam int IW = $clog2(POINTS)
) (
    input  logic                     i_clk,
    input  logic signed [DATA_W-1:0] i_coord,
    input  logic signed [DATA_W-1:0] i_origin,
    input  logic        [DATA_W-1:0] i_scale,
    output logic        [IW-1:0]     o_idx0,
    output logic        [IW-1:0]     o_idx1,
    output logic        [WGT_W-1:0]  o_weight
);

    localparam int SEG = POINTS - 1;
    localparam int POS_W = 2 * DATA_W - FRAC_W;
    localparam logic [POS_W-1:0] LIM = POS_W'(SEG) << FRAC_W;

    logic signed [DATA_W:0]   diff;
    logic        [DATA_W-1:0] n_mag;
    logic        [DATA_W-1:0] r_mag;
    logic      [2*DATA_W-1:0] r_prod;
    logic        [POS_W-1:0]  pos;
    logic        [IW-1:0]     idx;
    logic        [IW-1:0]     r_idx0;
    logic        [IW-1:0]     r_idx1;
    logic        [WGT_W-1:0]  r_weight;

    always_comb begin
        diff = (DATA_W+1)'(i_coord) - (DATA_W+1)'(i_origin);
        // at or below the origin the position is zero
        if (diff[DATA_W] || diff == '0) begin
            n_mag = '0;
        end else begin
            n_mag = diff[DATA_W-1:0];
        end
    end

    always_comb begin
        pos = r_prod[2*DATA_W-1:FRAC_W];
        if (pos > LIM) begin
            pos = LIM;
        end
        idx = pos[FRAC_W +: IW];
    end

    always_ff @(posedge i_clk) begin
        r_mag    <= n_mag;
        r_prod   <= r_mag * i_scale;
        r_idx0   <= idx;
        r_idx1   <= (idx < IW'(SEG)) ? idx + 1'b1 : IW'(SEG);
        r_weight <= pos[FRAC_W-1:0];
    end

    assign o_idx0   = r_idx0;
    assign o_idx1   = r_idx1;
    assign o_weight = r_weight;

endmodule

[src/bti_grid_mem.sv]
// sample grid in four row/column parity banks, one write and four corner reads a cycle
module bti_grid_mem import bti_pkg::*; #(
    parameter int POINTS_X = POINTS_X_DEF,
    parameter int POINTS_Y = POINTS_Y_DEF,
    localparam int CW = $clog2(POINTS_X),
    localparam int RW = $clog2(POINTS_Y)
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic        [RW-1:0]     i_wr_row,
    input  logic        [CW-1:0]     i_wr_col,
    input  logic        [DATA_W-1:0] i_wr_data,
    input  logic        [RW-1:0]     i_r0,
    input  logic        [RW-1:0]     i_r1,
    input  logic        [CW-1:0]     i_c0,
    input  logic        [CW-1:0]     i_c1,
    output logic signed [DATA_W-1:0] o_q00,
    output logic signed [DATA_W-1:0] o_q01,
    output logic signed [DATA_W-1:0] o_q10,
    output logic signed [DATA_W-1:0] o_q11
);

    localparam int RAW = (RW > 1) ? RW - 1 : 1;
    localparam int CAW = (CW > 1) ? CW - 1 : 1;
    localparam int BAW = RAW + CAW;
    localparam int BANK_DEPTH = 2 ** BAW;

    logic [DATA_W-1:0] bank_q [4];
    logic              r_r0p;
    logic              r_r1p;
    logic              r_c0p;
    logic              r_c1p;

    // the corners of one cell never share a bank unless they are the same entry
    for (genvar gb = 0; gb < 4; gb++) begin : g_bank
        localparam logic RP = ((gb / 2) == 1);
        localparam logic CP = ((gb % 2) == 1);

        logic [DATA_W-1:0] r_mem [BANK_DEPTH];
        logic [DATA_W-1:0] r_rdata;
        logic [RW-1:0]     rd_row;
        logic [CW-1:0]     rd_col;
        logic [BAW-1:0]    rd_addr;
        logic [BAW-1:0]    wr_addr;

        assign rd_row  = (i_r0[0] == RP) ? i_r0 : i_r1;
        assign rd_col  = (i_c0[0] == CP) ? i_c0 : i_c1;
        assign rd_addr = {RAW'(rd_row >> 1), CAW'(rd_col >> 1)};
        assign wr_addr = {RAW'(i_wr_row >> 1), CAW'(i_wr_col >> 1)};

        always_ff @(posedge i_clk) begin
            if (i_we && i_wr_row[0] == RP && i_wr_col[0] == CP) begin
                r_mem[wr_addr] <= i_wr_data;
            end
            r_rdata <= r_mem[rd_addr];
        end

        assign bank_q[gb] = r_rdata;
    end

    always_ff @(posedge i_clk) begin
        r_r0p <= i_r0[0];
        r_r1p <= i_r1[0];
        r_c0p <= i_c0[0];
        r_c1p <= i_c1[0];
    end

    assign o_q00 = bank_q[{r_r0p, r_c0p}];
    assign o_q01 = bank_q[{r_r0p, r_c1p}];
    assign o_q10 = bank_q[{r_r1p, r_c0p}];
    assign o_q11 = bank_q[{r_r1p, r_c1p}];

endmodule

[src/bti_lerp.sv]
// two-stage truncating linear interpolation a + (b - a) * w / 2^16
module bti_lerp import bti_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    input  logic        [WGT_W-1:0]  i_w,
    output logic signed [DATA_W-1:0] o_y
);

    localparam int PROD_W = DATA_W + WGT_W + 2;

    logic signed [DATA_W:0]   span;
    logic signed [WGT_W:0]    w_s;
    logic signed [DATA_W-1:0] r_a;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] adj;
    logic signed [PROD_W-1:0] quo;
    logic signed [DATA_W-1:0] r_y;

    always_comb begin
        span = (DATA_W+1)'(i_b) - (DATA_W+1)'(i_a);
        w_s  = $signed({1'b0, i_w});
        // round toward zero on a negative product
        adj  = r_prod + (r_prod[PROD_W-1] ? PROD_W'((1 << FRAC_W) - 1) : PROD_W'(0));
        quo  = adj >>> FRAC_W;
    end

    always_ff @(posedge i_clk) begin
        r_a    <= i_a;
        r_prod <= span * w_s;
        r_y    <= r_a + quo[DATA_W-1:0];
    end

    assign o_y = r_y;

endmodule

[src/bilinear_table_interpolator_top.sv]
// Bilinear table interpolator. One item, write or evaluate, is taken every clock cycle
// unless the input stalls; an evaluate result waits for the output in a
// 16-entry result queue, so the input stalls only once 16 results are in flight or
// queued. The grid sits in four banks split by row and column parity, so the four
// corners of a cell are read in the same cycle; writes go through the same pipeline
// stage as reads, so every item sees exactly the writes transferred before it. The grid
// has no reset and no clearing pass: an entry must be written before any query uses it.
// Configuration writes are always ready and must only happen while no item is in flight.
module bilinear_table_interpolator_top import bti_pkg::*; #(
    parameter int POINTS_X = POINTS_X_DEF,
    parameter int POINTS_Y = POINTS_Y_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic        [CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [DATA_W-1:0]    i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_action,
    input  logic        [3:0]           i_entry_row,
    input  logic        [3:0]           i_entry_col,
    input  logic signed [DATA_W-1:0]    i_entry_value,
    input  logic signed [DATA_W-1:0]    i_x,
    input  logic signed [DATA_W-1:0]    i_y,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [DATA_W-1:0]    o_z
);

    localparam int COL_W = $clog2(POINTS_X);
    localparam int ROW_W = $clog2(POINTS_Y);
    localparam int EV_LAT = 8;
    localparam int WR_LAT = 3;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int CNT_W = FIFO_AW + 1;

    logic signed [DATA_W-1:0] r_x_origin;
    logic signed [DATA_W-1:0] r_y_origin;
    logic        [DATA_W-1:0] r_x_scale;
    logic        [DATA_W-1:0] r_y_scale;

    logic in_xfer;
    logic ev_acc;
    logic wr_acc;
    logic out_xfer;
    logic push;

    logic [EV_LAT-1:0] r_ev;
    logic [WR_LAT-1:0] r_wr_vld;
    logic [ROW_W-1:0]  r_wr_row [WR_LAT];
    logic [COL_W-1:0]  r_wr_col [WR_LAT];
    logic [DATA_W-1:0] r_wr_val [WR_LAT];

    logic [COL_W-1:0] c0;
    logic [COL_W-1:0] c1;
    logic [ROW_W-1:0] r0;
    logic [ROW_W-1:0] r1;
    logic [WGT_W-1:0] wx;
    logic [WGT_W-1:0] wy;
    logic [WGT_W-1:0] r_wx_d;
    logic [WGT_W-1:0] r_wy_d [3];

    logic signed [DATA_W-1:0] q00;
    logic signed [DATA_W-1:0] q01;
    logic signed [DATA_W-1:0] q10;
    logic signed [DATA_W-1:0] q11;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    logic signed [DATA_W-1:0] z;

    logic        [DATA_W-1:0] r_fifo [FIFO_DEPTH];
    logic        [FIFO_AW-1:0] r_wptr;
    logic        [FIFO_AW-1:0] r_rptr;
    logic        [CNT_W-1:0]  r_fcnt;
    logic        [CNT_W-1:0]  n_fcnt;
    logic        [CNT_W-1:0]  r_cnt;
    logic        [CNT_W-1:0]  n_cnt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin <= X_ORIGIN_RST;
            r_y_origin <= Y_ORIGIN_RST;
            r_x_scale  <= X_SCALE_RST;
            r_y_scale  <= Y_SCALE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_X_ORIGIN: r_x_origin <= i_cfg_data;
                CFG_Y_ORIGIN: r_y_origin <= i_cfg_data;
                CFG_X_SCALE:  r_x_scale  <= i_cfg_data;
                CFG_Y_SCALE:  r_y_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // credit covers every evaluate in the pipeline plus the queue
    assign o_in_stall = (r_cnt == CNT_W'(FIFO_DEPTH));
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign ev_acc     = in_xfer && (i_action == ACT_EVAL);
    assign wr_acc     = in_xfer && (i_action == ACT_WRITE)
                        && (32'(i_entry_row) < POINTS_Y) && (32'(i_entry_col) < POINTS_X);
    assign out_xfer   = o_out_valid && !i_out_stall;
    assign push       = r_ev[EV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev     <= '0;
            r_wr_vld <= '0;
        end else begin
            r_ev     <= {r_ev[EV_LAT-2:0], ev_acc};
            r_wr_vld <= {r_wr_vld[WR_LAT-2:0], wr_acc};
        end
    end

    // write fields ride along so the write lands in the same stage as the reads
    always_ff @(posedge i_clk) begin
        r_wr_row[0] <= ROW_W'(i_entry_row);
        r_wr_col[0] <= COL_W'(i_entry_col);
        r_wr_val[0] <= i_entry_value;
        for (int i = 1; i < WR_LAT; i++) begin
            r_wr_row[i] <= r_wr_row[i-1];
            r_wr_col[i] <= r_wr_col[i-1];
            r_wr_val[i] <= r_wr_val[i-1];
        end
        r_wx_d    <= wx;
        r_wy_d[0] <= wy;
        r_wy_d[1] <= r_wy_d[0];
        r_wy_d[2] <= r_wy_d[1];
    end

    bti_position #(
        .POINTS (POINTS_X)
    ) u_pos_x (
        .i_clk    (i_clk),
        .i_coord  (i_x),
        .i_origin (r_x_origin),
        .i_scale  (r_x_scale),
        .o_idx0   (c0),
        .o_idx1   (c1),
        .o_weight (wx)
    );

    bti_position #(
        .POINTS (POINTS_Y)
    ) u_pos_y (
        .i_clk    (i_clk),
        .i_coord  (i_y),
        .i_origin (r_y_origin),
        .i_scale  (r_y_scale),
        .o_idx0   (r0),
        .o_idx1   (r1),
        .o_weight (wy)
    );

    bti_grid_mem #(
        .POINTS_X (POINTS_X),
        .POINTS_Y (POINTS_Y)
    ) u_grid (
        .i_clk     (i_clk),
        .i_we      (r_wr_vld[WR_LAT-1]),
        .i_wr_row  (r_wr_row[WR_LAT-1]),
        .i_wr_col  (r_wr_col[WR_LAT-1]),
        .i_wr_data (r_wr_val[WR_LAT-1]),
        .i_r0      (r0),
        .i_r1      (r1),
        .i_c0      (c0),
        .i_c1      (c1),
        .o_q00     (q00),
        .o_q01     (q01),
        .o_q10     (q10),
        .o_q11     (q11)
    );

    bti_lerp u_lerp_lo (
        .i_clk (i_clk),
        .i_a   (q00),
        .i_b   (q01),
        .i_w   (r_wx_d),
        .o_y   (lo)
    );

    bti_lerp u_lerp_hi (
        .i_clk (i_clk),
        .i_a   (q10),
        .i_b   (q11),
        .i_w   (r_wx_d),
        .o_y   (hi)
    );

    bti_lerp u_lerp_z (
        .i_clk (i_clk),
        .i_a   (lo),
        .i_b   (hi),
        .i_w   (r_wy_d[2]),
        .o_y   (z)
    );

    always_comb begin
        n_cnt  = r_cnt + CNT_W'(ev_acc) - CNT_W'(out_xfer);
        n_fcnt = r_fcnt + CNT_W'(push) - CNT_W'(out_xfer);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_fcnt <= '0;
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_fcnt <= n_fcnt;
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (out_xfer) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wptr] <= z;
        end
    end

    assign o_out_valid = (r_fcnt != '0);
    assign o_z         = r_fifo[r_rptr];

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(FIFO_DEPTH))
        else $error("credit count above queue depth");

    a_queue_in_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= r_cnt)
        else $error("queued results exceed outstanding credit");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_fcnt != CNT_W'(FIFO_DEPTH)))
        else $error("result pushed into a full queue");

    a_eval_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ev_acc |-> ##EV_LAT push)
        else $error("evaluate did not reach the result queue on time");

endmodule

[tb/bilinear_table_interpolator_checker.sv]
`timescale 1ns / 1ps
// transfer monitor, z predictor and result comparator for the bilinear table interpolator
module bilinear_table_interpolator_checker import bti_pkg::*; #(
    parameter int POINTS_X = POINTS_X_DEF,
    parameter int POINTS_Y = POINTS_Y_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic                     i_action,
    input  logic [3:0]               i_entry_row,
    input  logic [3:0]               i_entry_col,
    input  logic signed [DATA_W-1:0] i_entry_value,
    input  logic signed [DATA_W-1:0] i_x,
    input  logic signed [DATA_W-1:0] i_y,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic signed [DATA_W-1:0] i_z,
    output int                       o_mismatch_count,
    output int                       o_z_pending
);

    localparam int SEG_X = POINTS_X - 1;
    localparam int SEG_Y = POINTS_Y - 1;

    logic signed [DATA_W-1:0] table_mem [POINTS_Y*POINTS_X];
    logic        [DATA_W-1:0] x_origin_q;
    logic        [DATA_W-1:0] y_origin_q;
    logic        [DATA_W-1:0] x_scale_q;
    logic        [DATA_W-1:0] y_scale_q;
    logic signed [DATA_W-1:0] z_expected_q [$];
    int                       mismatch_count = 0;

    // grid position in Q16.16, clamped to 0..seg<<16
    function automatic logic [DATA_W-1:0] grid_pos(logic signed [DATA_W-1:0] coord,
                                                   logic signed [DATA_W-1:0] origin,
                                                   logic [DATA_W-1:0] scale, int seg);
        longint      delta;
        logic [63:0] delta_u;
        logic [63:0] pos;
        logic [63:0] lim;
        delta = longint'(coord) - longint'(origin);
        lim   = 64'(seg) << FRAC_W;
        if (delta <= 0)
            return '0;
        delta_u = delta;
        pos     = (delta_u * {32'd0, scale}) >> FRAC_W;
        return (pos > lim) ? lim[DATA_W-1:0] : pos[DATA_W-1:0];
    endfunction

    // truncating lerp, exact in 64 bits
    function automatic longint blend(longint a, longint b, logic [WGT_W-1:0] w);
        longint prod;
        prod = (b - a) * longint'({1'b0, w});
        return a + prod / (longint'(1) << WGT_W);
    endfunction

    function automatic longint grid_sample(int row, int col);
        return longint'(table_mem[row*POINTS_X + col]);
    endfunction

    function automatic logic signed [DATA_W-1:0] interp_z(logic signed [DATA_W-1:0] qx,
                                                          logic signed [DATA_W-1:0] qy);
        logic [DATA_W-1:0] px;
        logic [DATA_W-1:0] py;
        int                c0, c1, r0, r1;
        longint            lo, hi;
        px = grid_pos(qx, x_origin_q, x_scale_q, SEG_X);
        py = grid_pos(qy, y_origin_q, y_scale_q, SEG_Y);
        c0 = px >> FRAC_W;
        r0 = py >> FRAC_W;
        c1 = (c0 < SEG_X) ? c0 + 1 : SEG_X;
        r1 = (r0 < SEG_Y) ? r0 + 1 : SEG_Y;
        lo = blend(grid_sample(r0, c0), grid_sample(r0, c1), px[WGT_W-1:0]);
        hi = blend(grid_sample(r1, c0), grid_sample(r1, c1), px[WGT_W-1:0]);
        return DATA_W'(blend(lo, hi, py[WGT_W-1:0]));
    endfunction

    always @(posedge i_clk) begin : watch
        logic signed [DATA_W-1:0] z_want;
        if (!i_rst_n) begin
            x_origin_q = X_ORIGIN_RST;
            y_origin_q = Y_ORIGIN_RST;
            x_scale_q  = X_SCALE_RST;
            y_scale_q  = Y_SCALE_RST;
            z_expected_q.delete();
        end else begin
            // results first, so a transfer in this cycle can never match itself
            if (i_out_valid && !i_out_stall) begin
                if (z_expected_q.size() == 0) begin
                    $error("z: expected nothing, actual %0d", i_z);
                    mismatch_count++;
                end else begin
                    z_want = z_expected_q.pop_front();
                    if (i_z !== z_want) begin
                        $error("z: expected %0d, actual %0d", z_want, i_z);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_X_ORIGIN: x_origin_q = i_cfg_data;
                    CFG_Y_ORIGIN: y_origin_q = i_cfg_data;
                    CFG_X_SCALE:  x_scale_q  = i_cfg_data;
                    CFG_Y_SCALE:  y_scale_q  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (t_action'(i_action) == ACT_WRITE) begin
                    if (int'(i_entry_row) < POINTS_Y && int'(i_entry_col) < POINTS_X)
                        table_mem[int'(i_entry_row)*POINTS_X + int'(i_entry_col)] =
                            i_entry_value;
                end else begin
                    z_expected_q.push_back(interp_z(i_x, i_y));
                end
            end
        end
        o_mismatch_count <= mismatch_count;
        o_z_pending      <= z_expected_q.size();
    end

endmodule

[tb/bilinear_table_interpolator_top_tb.sv]
`timescale 1ns / 1ps
// testbench top for the bilinear table interpolator: clock, reset, stimulus and verdict
module bilinear_table_interpolator_top_tb;
    import bti_pkg::*;

    localparam int POINTS_X        = POINTS_X_DEF;
    localparam int POINTS_Y        = POINTS_Y_DEF;
    localparam int SEG_X           = POINTS_X - 1;
    localparam int SEG_Y           = POINTS_Y - 1;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTING_COUNT   = 6;
    localparam int ITEMS_PER_SET   = 130;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_valid   = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index   = '0;
    logic [DATA_W-1:0]        i_cfg_data    = '0;
    logic                     i_in_valid    = 1'b0;
    logic                     o_in_stall;
    logic                     i_action      = 1'b0;
    logic [3:0]               i_entry_row   = '0;
    logic [3:0]               i_entry_col   = '0;
    logic signed [DATA_W-1:0] i_entry_value = '0;
    logic signed [DATA_W-1:0] i_x           = '0;
    logic signed [DATA_W-1:0] i_y           = '0;
    logic                     o_out_valid;
    logic                     i_out_stall   = 1'b0;
    logic signed [DATA_W-1:0] o_z;

    int mismatch_count;
    int z_pending;
    int send_idle_pct     = 0;
    int recv_idle_pct     = 0;
    int hold_off_req_cnt  = 0;
    int hold_off_seen_cnt = 0;
    int hold_off_left     = 0;
    int cycle_cnt         = 0;

    // configuration as last written, used to aim query coordinates at the grid
    logic [DATA_W-1:0] cfg_x_origin = X_ORIGIN_RST;
    logic [DATA_W-1:0] cfg_y_origin = Y_ORIGIN_RST;
    logic [DATA_W-1:0] cfg_x_scale  = X_SCALE_RST;
    logic [DATA_W-1:0] cfg_y_scale  = Y_SCALE_RST;

    bilinear_table_interpolator_top #(
        .POINTS_X (POINTS_X),
        .POINTS_Y (POINTS_Y)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_entry_row   (i_entry_row),
        .i_entry_col   (i_entry_col),
        .i_entry_value (i_entry_value),
        .i_x           (i_x),
        .i_y           (i_y),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_z           (o_z)
    );

    bilinear_table_interpolator_checker #(
        .POINTS_X (POINTS_X),
        .POINTS_Y (POINTS_Y)
    ) i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_entry_row      (i_entry_row),
        .i_entry_col      (i_entry_col),
        .i_entry_value    (i_entry_value),
        .i_x              (i_x),
        .i_y              (i_y),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_z              (o_z),
        .o_mismatch_count (mismatch_count),
        .o_z_pending      (z_pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stall, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_off_seen_cnt != hold_off_req_cnt) begin
            hold_off_seen_cnt <= hold_off_req_cnt;
            hold_off_left     <= HOLD_OFF_CYCLES;
            i_out_stall       <= 1'b1;
        end else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            i_out_stall   <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_item(input t_action act, input logic [3:0] row, input logic [3:0] col,
                             input logic [DATA_W-1:0] value, input logic [DATA_W-1:0] qx,
                             input logic [DATA_W-1:0] qy);
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_entry_row   <= row;
        i_entry_col   <= col;
        i_entry_value <= value;
        i_x           <= qx;
        i_y           <= qy;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic query(input logic [DATA_W-1:0] qx, input logic [DATA_W-1:0] qy);
        send_item(ACT_EVAL, 4'($urandom), 4'($urandom), $urandom, qx, qy);
    endtask

    // drop valid, wait for every expected z, then let the pipeline empty
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (z_pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [DATA_W-1:0] xo, input logic [DATA_W-1:0] yo,
                               input logic [DATA_W-1:0] xs, input logic [DATA_W-1:0] ys);
        t_cfg_idx          reg_order [4] = '{CFG_X_ORIGIN, CFG_Y_ORIGIN, CFG_X_SCALE,
                                             CFG_Y_SCALE};
        logic [DATA_W-1:0] reg_value [4];
        reg_value = '{xo, yo, xs, ys};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_order[k];
            i_cfg_data  <= reg_value[k];
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
        end
        i_cfg_valid  <= 1'b0;
        cfg_x_origin = xo;
        cfg_y_origin = yo;
        cfg_x_scale  = xs;
        cfg_y_scale  = ys;
    endtask

    function automatic logic [DATA_W-1:0] pick_entry();
        case ($urandom_range(11))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // mostly coordinates that land on the grid, some at its edges, some anywhere
    function automatic logic [DATA_W-1:0] pick_coord(logic [DATA_W-1:0] origin,
                                                     logic [DATA_W-1:0] scale, int seg);
        longint reach;
        longint base;
        int     sel;
        base = longint'(signed'(origin));
        if (scale == '0)
            reach = longint'(1) << 20;
        else
            reach = ((longint'(seg) << 32) / longint'({32'd0, scale})) + 2;
        if (reach > (longint'(1) << 31))
            reach = longint'(1) << 31;
        sel = $urandom_range(99);
        if (sel < 75)
            return DATA_W'(base - 2 + longint'($urandom_range(32'(reach + 4))));
        if (sel < 88) begin
            case ($urandom_range(4))
                0:       return origin;
                1:       return origin - 1;
                2:       return origin + 1;
                3:       return DATA_W'(base + reach - 2);
                default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            endcase
        end
        return $urandom;
    endfunction

    initial begin
        logic [DATA_W-1:0] entry;
        send_idle_pct = 11;
        recv_idle_pct <= 58;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // load the whole table; max and min checkerboard at both grid corners
        for (int r = 0; r < POINTS_Y; r++) begin
            for (int c = 0; c < POINTS_X; c++) begin
                entry = pick_entry();
                if ((r < 2 && c < 2) || (r > POINTS_Y - 3 && c > POINTS_X - 3))
                    entry = ((r + c) % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
                send_item(ACT_WRITE, 4'(r), 4'(c), entry, $urandom, $urandom);
            end
        end

        // reset configuration: one unit spans the grid
        query(32'd0, 32'd0);
        query(32'h0000_0888, 32'h0000_0888);
        query(32'd4369, 32'd4369);
        query(32'h0001_0000, 32'h0001_0000);
        query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        query(32'h8000_0000, 32'hFFFF_FFFF);
        query(32'd61166, 32'd4369);
        send_item(ACT_WRITE, 4'd0, 4'd0, 32'h8000_0000, $urandom, $urandom);
        query(32'd0, 32'd0);
        send_item(ACT_WRITE, 4'd15, 4'd15, 32'h7FFF_FFFF, $urandom, $urandom);
        query(32'd65535, 32'd65535);
        query(32'd65535, 32'd0);

        // zero x scale, full y scale from the lowest origin
        wait_idle();
        load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF);
        query(32'h7FFF_FFFF, 32'h8000_0000);
        query(32'h8000_0000, 32'h8000_0001);
        query(32'h0000_0000, 32'h8000_000E);
        query(32'hFFFF_FFFF, 32'h8000_000F);
        query(32'h1234_5678, 32'h7FFF_FFFF);

        for (int s = 0; s < SETTING_COUNT; s++) begin
            wait_idle();
            case (s)
                0: load_config(X_ORIGIN_RST, Y_ORIGIN_RST, X_SCALE_RST, Y_SCALE_RST);
                1: load_config(32'hFFF8_0000, 32'h0003_8000, 32'd61440, 32'd245760);
                2: load_config(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0);
                3: load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF);
                4: load_config($urandom, $urandom, 32'd1, $urandom_range(32'h0040_0000,
                                                                        32'h0000_4000));
                default: load_config($urandom, $urandom, $urandom, $urandom);
            endcase
            case (s / 2)
                0: begin
                    send_idle_pct = 11;
                    recv_idle_pct <= 58;
                end
                1: begin
                    send_idle_pct = 58;
                    recv_idle_pct <= 11;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            // long result hold-off while items keep coming, so the input stalls
            if (s == 0 || s == 4)
                hold_off_req_cnt <= hold_off_req_cnt + 1;
            for (int n = 0; n < ITEMS_PER_SET; n++) begin
                if ($urandom_range(99) < 72)
                    query(pick_coord(cfg_x_origin, cfg_x_scale, SEG_X),
                          pick_coord(cfg_y_origin, cfg_y_scale, SEG_Y));
                else
                    send_item(ACT_WRITE, 4'($urandom), 4'($urandom), pick_entry(),
                              $urandom, $urandom);
            end
        end

        wait_idle();
        if (mismatch_count == 0 && z_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
src/bti_pkg.sv
src/bti_position.sv
src/bti_grid_mem.sv
src/bti_lerp.sv
src/bilinear_table_interpolator_top.sv
tb/bilinear_table_interpolator_checker.sv
tb/bilinear_table_interpolator_top_tb.sv
